[rtl/saia_pkg.sv]
// Shared types and constants for the shift-add integer ALU.
`timescale 1ns / 1ps

package saia_pkg;

  localparam int DataWidthDef = 32;
  localparam int ReqTypeW     = 3;
  localparam int QueueDepth   = 2;

  // Request opcodes as they arrive on the input stream
  localparam logic [ReqTypeW-1:0] OpAdd = 3'd0;
  localparam logic [ReqTypeW-1:0] OpSub = 3'd1;
  localparam logic [ReqTypeW-1:0] OpMul = 3'd2;
  localparam logic [ReqTypeW-1:0] OpDiv = 3'd3;
  localparam logic [ReqTypeW-1:0] OpMod = 3'd4;

  // Work class decided by the front end; KindZero returns 0 with the given status
  typedef enum logic [2:0] {
    KindAdd  = 3'd0,
    KindSub  = 3'd1,
    KindMul  = 3'd2,
    KindDiv  = 3'd3,
    KindMod  = 3'd4,
    KindZero = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  status;
  } ctl_t;

endpackage

[rtl/shift_add_integer_alu.sv]
// Add and subtract pass through the request queue and the output register; multiply,
// divide and modulo pass through the queue, the one-bit-per-cycle shift-add and
// restoring-divide loop in the execution unit, its done state and the output register.
// Throughput: one add/sub per cycle while the output is free; no request starts while
// the loop runs, but a two-entry queue lets input transfers continue meanwhile.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
`timescale 1ns / 1ps

module shift_add_integer_alu #(
  parameter int DATA_WIDTH = saia_pkg::DataWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // operand_a, operand_b (from bit 0 up), zero padded to whole bytes
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // req_type
  input  logic [saia_pkg::ReqTypeW-1:0]        s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_value, zero padded to whole bytes
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // status
  output logic                                 m_axis_tuser
);

  localparam int OutDataW = ((DATA_WIDTH + 7) / 8) * 8;

  logic                  push, full, pop, q_valid;
  saia_pkg::ctl_t        push_ctl, pop_ctl;
  logic [DATA_WIDTH-1:0] op_a, op_b, pop_a, pop_b, result_value;

  assign op_a = s_axis_tdata[DATA_WIDTH-1:0];
  assign op_b = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  saia_front #(
    .DataWidth (DATA_WIDTH)
  ) u_front (
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .operand_a_i (op_a),
    .operand_b_i (op_b),
    .push_o      (push),
    .push_ctl_o  (push_ctl),
    .full_i      (full)
  );

  saia_queue #(
    .DataWidth (DATA_WIDTH),
    .Depth     (saia_pkg::QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ctl_i (push_ctl),
    .push_a_i   (op_a),
    .push_b_i   (op_b),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_ctl_o  (pop_ctl),
    .pop_a_o    (pop_a),
    .pop_b_o    (pop_b)
  );

  saia_exec #(
    .DataWidth (DATA_WIDTH)
  ) u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .ctl_i          (pop_ctl),
    .a_i            (pop_a),
    .b_i            (pop_b),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .result_value_o (result_value),
    .status_o       (m_axis_tuser)
  );

  assign m_axis_tdata = OutDataW'(result_value);

endmodule

[rtl/saia_front.sv]
// Front end: accepts requests, classifies them and pushes them into the queue.
`timescale 1ns / 1ps

module saia_front #(
  parameter int DataWidth = saia_pkg::DataWidthDef
) (
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [saia_pkg::ReqTypeW-1:0] req_type_i,
  input  logic [DataWidth-1:0]          operand_a_i,
  input  logic [DataWidth-1:0]          operand_b_i,
  output logic                          push_o,
  output saia_pkg::ctl_t                push_ctl_o,
  input  logic                          full_i
);

  logic bad_div;

  // Divide needs a non-negative dividend and a strictly positive divisor
  assign bad_div = (operand_b_i == '0) || operand_b_i[DataWidth-1] || operand_a_i[DataWidth-1];

  always_comb begin
    push_ctl_o.status = 1'b0;
    unique case (req_type_i) inside
      saia_pkg::OpAdd: push_ctl_o.kind = saia_pkg::KindAdd;
      saia_pkg::OpSub: push_ctl_o.kind = saia_pkg::KindSub;
      saia_pkg::OpMul: push_ctl_o.kind = saia_pkg::KindMul;
      saia_pkg::OpDiv, saia_pkg::OpMod: begin
        if (bad_div) begin
          push_ctl_o.kind   = saia_pkg::KindZero;
          push_ctl_o.status = 1'b1;
        end else if (req_type_i == saia_pkg::OpDiv) begin
          push_ctl_o.kind = saia_pkg::KindDiv;
        end else begin
          push_ctl_o.kind = saia_pkg::KindMod;
        end
      end
      default: push_ctl_o.kind = saia_pkg::KindZero;
    endcase
  end

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

endmodule

[rtl/saia_queue.sv]
// Short request queue between the front end and the execution unit.
`timescale 1ns / 1ps

module saia_queue #(
  parameter int DataWidth = saia_pkg::DataWidthDef,
  parameter int Depth     = saia_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  saia_pkg::ctl_t       push_ctl_i,
  input  logic [DataWidth-1:0] push_a_i,
  input  logic [DataWidth-1:0] push_b_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output saia_pkg::ctl_t       pop_ctl_o,
  output logic [DataWidth-1:0] pop_a_o,
  output logic [DataWidth-1:0] pop_b_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  saia_pkg::ctl_t       ctl_q [Depth];
  logic [DataWidth-1:0] a_q   [Depth];
  logic [DataWidth-1:0] b_q   [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign pop_ctl_o = ctl_q[rd_ptr_q];
  assign pop_a_o   = a_q[rd_ptr_q];
  assign pop_b_o   = b_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_q[wr_ptr_q] <= push_ctl_i;
      a_q[wr_ptr_q]   <= push_a_i;
      b_q[wr_ptr_q]   <= push_b_i;
    end
  end

endmodule

[rtl/saia_exec.sv]
// Execution unit: direct add/sub, bit-serial shift-add multiply and restoring divide.
`timescale 1ns / 1ps

module saia_exec #(
  parameter int DataWidth = saia_pkg::DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  saia_pkg::ctl_t       ctl_i,
  input  logic [DataWidth-1:0] a_i,
  input  logic [DataWidth-1:0] b_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [DataWidth-1:0] result_value_o,
  output logic                 status_o
);

  localparam int CntW = $clog2(DataWidth);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StBusy = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e                state_q, state_d;
  saia_pkg::kind_e       kind_q, kind_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DataWidth-1:0]  acc_q, acc_d;
  logic [DataWidth-1:0]  x_q, x_d;
  logic [DataWidth-1:0]  y_q, y_d;
  logic                  out_valid_q, out_valid_d;
  logic [DataWidth-1:0]  out_data_q, out_data_d;
  logic                  out_status_q, out_status_d;
  logic                  out_free;
  logic [DataWidth-1:0]  shift_r;
  logic [DataWidth:0]    diff;

  // Partial remainder stays below the divisor, so one shift still fits the word
  assign shift_r = {acc_q[DataWidth-2:0], x_q[DataWidth-1]};
  assign diff    = {1'b0, shift_r} - {1'b0, y_q};
  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    x_d          = x_q;
    y_d          = y_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    pop_o        = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (valid_i && out_free) begin
          pop_o = 1'b1;
          case (ctl_i.kind) inside
            saia_pkg::KindAdd: begin
              out_valid_d  = 1'b1;
              out_data_d   = a_i + b_i;
              out_status_d = 1'b0;
            end
            saia_pkg::KindSub: begin
              out_valid_d  = 1'b1;
              out_data_d   = a_i - b_i;
              out_status_d = 1'b0;
            end
            saia_pkg::KindMul, saia_pkg::KindDiv, saia_pkg::KindMod: begin
              kind_d  = ctl_i.kind;
              acc_d   = '0;
              x_d     = a_i;
              y_d     = b_i;
              cnt_d   = CntW'(DataWidth - 1);
              state_d = StBusy;
            end
            default: begin
              out_valid_d  = 1'b1;
              out_data_d   = '0;
              out_status_d = ctl_i.status;
            end
          endcase
        end
      end
      StBusy: begin
        if (kind_q == saia_pkg::KindMul) begin
          // Add the shifted multiplicand for each set multiplier bit
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d = {x_q[DataWidth-2:0], 1'b0};
          y_d = {1'b0, y_q[DataWidth-1:1]};
        end else begin
          // Restore unless the trial subtraction stays non-negative
          acc_d = diff[DataWidth] ? shift_r : diff[DataWidth-1:0];
          x_d   = {x_q[DataWidth-2:0], !diff[DataWidth]};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = (kind_q == saia_pkg::KindDiv) ? x_q : acc_q;
          out_status_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    cnt_q        <= cnt_d;
    acc_q        <= acc_d;
    x_q          <= x_d;
    y_q          <= y_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign m_valid_o      = out_valid_q;
  assign result_value_o = out_data_q;
  assign status_o       = out_status_q;

endmodule

[tb/sv/testbench.sv]
// Self-checking stream testbench for the shift-add integer ALU.
`timescale 1ns / 1ps

module testbench;

  localparam int DW       = saia_pkg::DataWidthDef;
  localparam int OpW      = saia_pkg::ReqTypeW;
  localparam int InW      = ((2*DW+7)/8)*8;
  localparam int OutW     = ((DW+7)/8)*8;
  localparam int MaxCycle = 400000;
  localparam int NumRand  = 850;

  // Opcodes that the block does not define; they return 0 with status ok
  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  localparam logic [DW-1:0] MaxPos = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MinNeg = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] AllOne = {DW{1'b1}};

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata;   // operand_a, operand_b
  logic [OpW-1:0]   s_axis_tuser;   // req_type
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OutW-1:0]  m_axis_tdata;   // result_value
  logic             m_axis_tuser;   // status

  shift_add_integer_alu #(.DATA_WIDTH(DW)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  class alu_scoreboard;
    typedef struct {
      logic [DW-1:0] value;
      logic          status;
    } alu_result_t;

    alu_result_t result_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Compute the expected result of one accepted request
    function void note_request(logic [OpW-1:0] op, logic [DW-1:0] a,
                               logic [DW-1:0] b);
      alu_result_t exp_res;
      logic [2*DW-1:0] product;
      exp_res.value  = '0;
      exp_res.status = 1'b0;
      product = a * b;
      case (op) inside
        saia_pkg::OpAdd: exp_res.value = a + b;
        saia_pkg::OpSub: exp_res.value = a - b;
        saia_pkg::OpMul: exp_res.value = product[DW-1:0];
        saia_pkg::OpDiv, saia_pkg::OpMod: begin
          if (b == '0 || b[DW-1] || a[DW-1]) begin
            exp_res.status = 1'b1;
          end else begin
            exp_res.value = (op == saia_pkg::OpDiv) ? a / b : a % b;
          end
        end
        default: ;
      endcase
      result_q.push_back(exp_res);
    endfunction

    function void check_result(logic [DW-1:0] value, logic status);
      alu_result_t exp_res;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result: value %h status %b", $time, value, status);
        errors++;
        return;
      end
      exp_res = result_q.pop_front();
      if (value !== exp_res.value) begin
        $display("%0t: result value mismatch: expected %h actual %h",
                 $time, exp_res.value, value);
        errors++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status mismatch: expected %b actual %b",
                 $time, exp_res.status, status);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return result_q.size();
    endfunction
  endclass

  alu_scoreboard sb;
  bit            idle_on;
  int unsigned   cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MaxCycle) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[DW-1:0], m_axis_tuser);
    end
  end

  // Receiver: random stall bursts while idling is on
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_request(input logic [OpW-1:0] op, input logic [DW-1:0] a,
                              input logic [DW-1:0] b);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, a};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, a, b);
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = DW'($urandom_range(0, 16));
      1: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = MaxPos;
          2:       v = MinNeg;
          3:       v = AllOne;
          default: v = DW'(1);
        endcase
      end
      2: v = DW'($urandom() >> $urandom_range(0, 31));
      3: v = '0 - DW'($urandom_range(1, 16));
      default: v = DW'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_random();
    logic [OpW-1:0] op;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    a = pick_operand();
    b = pick_operand();
    case ($urandom_range(0, 19)) inside
      0, 1, 2, 3:     op = saia_pkg::OpAdd;
      4, 5, 6, 7:     op = saia_pkg::OpSub;
      8, 9, 10, 11:   op = saia_pkg::OpMul;
      12, 13, 14, 15: op = saia_pkg::OpDiv;
      16, 17, 18:     op = saia_pkg::OpMod;
      default: begin
        case ($urandom_range(0, 2))
          0:       op = OpSpare5;
          1:       op = OpSpare6;
          default: op = OpSpare7;
        endcase
      end
    endcase
    // Keep most divides well formed so the loop does real work
    if ((op == saia_pkg::OpDiv || op == saia_pkg::OpMod) && $urandom_range(0, 6) != 0) begin
      a[DW-1] = 1'b0;
      b[DW-1] = 1'b0;
      if (b == '0) b = DW'(1);
    end
    send_request(op, a, b);
  endtask

  initial begin
    sb            = new();
    idle_on       = 1'b1;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = saia_pkg::OpAdd;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: wrap points, multiplier corner cases, bad divide operands, spare opcodes
    send_request(saia_pkg::OpAdd, MaxPos, DW'(1));
    send_request(saia_pkg::OpAdd, MinNeg, AllOne);
    send_request(saia_pkg::OpAdd, AllOne, AllOne);
    send_request(saia_pkg::OpSub, '0, MinNeg);
    send_request(saia_pkg::OpSub, MinNeg, DW'(1));
    send_request(saia_pkg::OpSub, MaxPos, AllOne);
    send_request(saia_pkg::OpMul, MaxPos, MaxPos);
    send_request(saia_pkg::OpMul, DW'(32'h1234_5678), '0);
    send_request(saia_pkg::OpMul, AllOne, AllOne);
    send_request(saia_pkg::OpMul, MinNeg, AllOne);
    send_request(saia_pkg::OpMul, DW'(32'hdead_beef), DW'(32'h8765_4321));
    send_request(saia_pkg::OpDiv, MaxPos, DW'(1));
    send_request(saia_pkg::OpDiv, DW'(7), DW'(3));
    send_request(saia_pkg::OpDiv, DW'(5), DW'(7));
    send_request(saia_pkg::OpDiv, '0, DW'(5));
    send_request(saia_pkg::OpDiv, DW'(9), '0);
    send_request(saia_pkg::OpDiv, DW'(9), AllOne);
    send_request(saia_pkg::OpDiv, '0 - DW'(5), DW'(3));
    send_request(saia_pkg::OpMod, DW'(100), DW'(7));
    send_request(saia_pkg::OpMod, MaxPos, MaxPos);
    send_request(saia_pkg::OpMod, DW'(12), '0);
    send_request(saia_pkg::OpMod, AllOne, MinNeg);
    send_request(OpSpare5, AllOne, AllOne);
    send_request(OpSpare6, MaxPos, DW'(3));
    send_request(OpSpare7, MinNeg, MinNeg);
    wait_drained();

    for (int i = 0; i < NumRand; i++) begin
      idle_on = !((i >= 250 && i < 320) || i >= 700);
      if (i == 420) wait_drained();
      if (idle_on && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 11));
      send_random();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/saia_pkg.sv
rtl/saia_front.sv
rtl/saia_queue.sv
rtl/saia_exec.sv
rtl/shift_add_integer_alu.sv
tb/sv/testbench.sv
